### rtl/core/pmt_pkg.sv
package pmt_pkg;

    localparam int MAX_POINTS_DEF = 128;
    localparam int COORD_W        = 10;
    localparam int VIEW_W         = 7;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int S_TDATA_W      = 32;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 40;
    localparam int OUT_BYTE_W     = 8;

    localparam logic [1:0] ACT_CLICK  = 2'd0;
    localparam logic [1:0] ACT_NAV    = 2'd1;
    localparam logic [1:0] ACT_ORIENT = 2'd2;

    localparam logic [1:0] BTN_ADD = 2'd1;
    localparam logic [1:0] BTN_DEL = 2'd2;

    localparam logic signed [2:0] DIR_FIRST = 3'b101;
    localparam logic signed [2:0] DIR_PREV  = 3'b111;
    localparam logic signed [2:0] DIR_NEXT  = 3'b001;
    localparam logic signed [2:0] DIR_LAST  = 3'b011;

    localparam logic [CFG_ADDR_W-1:0] ADDR_VIEW_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_VIEW_HEIGHT = 3'd4;

    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 7'd20;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 7'd15;

    typedef struct packed {
        logic [COORD_W-1:0] origin;
        logic [COORD_W-1:0] pos;
        logic [VIEW_W-1:0]  span;
    } scroll_req_t;

endpackage

### rtl/core/point_marker_table.sv
// Marker table for a tile map. Each transaction on the s_ side carries one action and
// yields exactly one transaction on the m_ side with the hit flag, the selection, the
// marker count and the view origin after the action. Markers live in a single-port-write,
// registered-read RAM with no reset; only entries below the count are ever read. A click
// scans the table one entry per cycle through a single comparator and stops early on a
// match; a right click that deletes then compacts the table one entry per cycle. Orient
// reads the RAM, then runs the shared scroll unit on x and then on y.
// s_tready is high only while no action is in progress; a finished result waits in the
// output register and the next transaction may be accepted meanwhile. view_width and
// view_height sit at byte addresses 0 and 4 of the APB port and may be written only while
// the block is idle.
module point_marker_table #(
    parameter int MAX_POINTS = pmt_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x[9:0], pos_y[19:10], button[21:20], direction[24:22], zero[31:25]
    input  logic [pmt_pkg::S_TDATA_W-1:0]       s_tdata,
    // action[1:0]
    input  logic [pmt_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit[0], selected[8:1], marker_count[16:9], view_x[26:17], view_y[36:27], zero[39:37]
    output logic [pmt_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pmt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pmt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [pmt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = IW + 1;
    localparam int NW = SW + 1;
    localparam int XW = pmt_pkg::COORD_W;
    localparam int VW = pmt_pkg::VIEW_W;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEARCH   = 6'b000010,
        ST_SHIFT    = 6'b000100,
        ST_ORIENT_X = 6'b001000,
        ST_ORIENT_Y = 6'b010000,
        ST_RESP     = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [XW-1:0]                px_reg, px_next;
    logic [XW-1:0]                py_reg, py_next;
    logic [1:0]                   btn_reg, btn_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [SW-1:0]         sel_reg, sel_next;
    logic [XW-1:0]                win_x_reg, win_x_next;
    logic [XW-1:0]                win_y_reg, win_y_next;
    logic                         hit_reg, hit_next;
    logic [VW-1:0]                width_reg, height_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pmt_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [XW-1:0]                in_x;
    logic [XW-1:0]                in_y;
    logic [1:0]                   in_btn;
    logic signed [2:0]            in_dir;
    logic [1:0]                   in_act;

    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [2*XW-1:0]              ram_wdata;
    logic                         ram_re;
    logic [IW-1:0]                ram_raddr;
    logic [2*XW-1:0]              ram_rdata;

    pmt_pkg::scroll_req_t         scroll_req;
    logic [XW-1:0]                scroll_res;

    logic signed [NW-1:0]         cnt_s;
    logic signed [NW-1:0]         sel_s;
    logic signed [NW-1:0]         cnt_m1;
    logic signed [NW-1:0]         step_s;
    logic signed [NW-1:0]         nav_s;
    logic                         orient_ok;
    logic                         match;
    logic [CW-1:0]                wr_idx;
    logic                         cfg_wr;

    assign in_x   = s_tdata[XW-1:0];
    assign in_y   = s_tdata[2*XW-1:XW];
    assign in_btn = s_tdata[2*XW+1:2*XW];
    assign in_dir = s_tdata[2*XW+4:2*XW+2];
    assign in_act = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;

    pmt_marker_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (IW),
        .DW    (2 * XW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pmt_scroll_unit u_scroll (
        .req    (scroll_req),
        .result (scroll_res)
    );

    assign cnt_s     = NW'(count_reg);
    assign sel_s     = NW'(sel_reg);
    assign cnt_m1    = cnt_s - NW'(1);
    assign orient_ok = (count_reg != '0) && !sel_reg[SW-1] && (sel_s < cnt_s);
    assign match     = pend_reg && (ram_rdata == {py_reg, px_reg});
    assign wr_idx    = idx_reg - CW'(2);

    always_comb begin
        nav_s  = sel_s;
        step_s = sel_s;
        case (in_dir)
            pmt_pkg::DIR_FIRST: begin
                nav_s = '0;
            end
            pmt_pkg::DIR_PREV: begin
                step_s = sel_s - NW'(1);
                nav_s  = (step_s[NW-1] || step_s >= cnt_s) ? cnt_m1 : step_s;
            end
            pmt_pkg::DIR_NEXT: begin
                step_s = sel_s + NW'(1);
                nav_s  = (step_s[NW-1] || step_s >= cnt_s) ? '0 : step_s;
            end
            pmt_pkg::DIR_LAST: begin
                nav_s = cnt_m1;
            end
            default: begin
                nav_s = sel_s;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        btn_next      = btn_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        sel_next      = sel_reg;
        win_x_next    = win_x_reg;
        win_y_next    = win_y_reg;
        hit_next      = hit_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IW-1:0];
        ram_wdata     = {py_reg, px_reg};
        ram_re        = 1'b0;
        ram_raddr     = idx_reg[IW-1:0];
        scroll_req.origin = win_x_reg;
        scroll_req.pos    = ram_rdata[XW-1:0];
        scroll_req.span   = width_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    px_next  = in_x;
                    py_next  = in_y;
                    btn_next = in_btn;
                    hit_next = 1'b0;
                    case (in_act)
                        pmt_pkg::ACT_CLICK: begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SEARCH;
                        end
                        pmt_pkg::ACT_NAV: begin
                            if (count_reg != '0) begin
                                sel_next = SW'(nav_s);
                                hit_next = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        pmt_pkg::ACT_ORIENT: begin
                            if (orient_ok) begin
                                ram_re     = 1'b1;
                                ram_raddr  = sel_reg[IW-1:0];
                                hit_next   = 1'b1;
                                state_next = ST_ORIENT_X;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    hit_next  = 1'b1;
                    pend_next = 1'b0;
                    state_next = (btn_reg == pmt_pkg::BTN_DEL) ? ST_SHIFT : ST_RESP;
                end else if (idx_reg < count_reg) begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (btn_reg == pmt_pkg::BTN_ADD && count_reg < CW'(MAX_POINTS)) begin
                        ram_we     = 1'b1;
                        sel_next   = SW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx[IW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < count_reg) begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - CW'(1);
                        if (sel_s >= cnt_m1) begin
                            sel_next = SW'(cnt_m1 - NW'(1));
                        end
                        state_next = ST_RESP;
                    end
                end
            end
            ST_ORIENT_X: begin
                win_x_next = scroll_res;
                state_next = ST_ORIENT_Y;
            end
            ST_ORIENT_Y: begin
                scroll_req.origin = win_y_reg;
                scroll_req.pos    = ram_rdata[2*XW-1:XW];
                scroll_req.span   = height_reg;
                win_y_next = scroll_res;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, win_y_reg, win_x_reg,
                                     pmt_pkg::OUT_BYTE_W'(count_reg),
                                     pmt_pkg::OUT_BYTE_W'(sel_reg), hit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            sel_reg      <= '0;
            win_x_reg    <= '0;
            win_y_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sel_reg      <= sel_next;
            win_x_reg    <= win_x_next;
            win_y_reg    <= win_y_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        btn_reg     <= btn_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pmt_pkg::VIEW_WIDTH_RST;
            height_reg <= pmt_pkg::VIEW_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr == pmt_pkg::ADDR_VIEW_WIDTH) begin
                width_reg <= pwdata[VW-1:0];
            end
            if (paddr == pmt_pkg::ADDR_VIEW_HEIGHT) begin
                height_reg <= pwdata[VW-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            pmt_pkg::ADDR_VIEW_WIDTH: begin
                prdata = pmt_pkg::CFG_DATA_W'(width_reg);
            end
            pmt_pkg::ADDR_VIEW_HEIGHT: begin
                prdata = pmt_pkg::CFG_DATA_W'(height_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

### rtl/core/pmt_marker_ram.sv
module pmt_marker_ram #(
    parameter int DEPTH = pmt_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(pmt_pkg::MAX_POINTS_DEF),
    parameter int DW    = 2 * pmt_pkg::COORD_W
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/pmt_scroll_unit.sv
module pmt_scroll_unit (
    input  pmt_pkg::scroll_req_t          req,
    output logic [pmt_pkg::COORD_W-1:0]   result
);

    logic [pmt_pkg::VIEW_W-1:0]  span_eff;
    logic [pmt_pkg::COORD_W:0]   last_vis;
    logic [pmt_pkg::COORD_W:0]   back_off;

    always_comb begin
        span_eff = (req.span == '0) ? pmt_pkg::VIEW_W'(1) : req.span;
        last_vis = {1'b0, req.origin} + (pmt_pkg::COORD_W + 1)'(span_eff)
                   - (pmt_pkg::COORD_W + 1)'(1);
        back_off = {1'b0, req.pos} + (pmt_pkg::COORD_W + 1)'(1)
                   - (pmt_pkg::COORD_W + 1)'(span_eff);
        if (req.pos < req.origin) begin
            result = req.pos;
        end else if ({1'b0, req.pos} > last_vis) begin
            result = back_off[pmt_pkg::COORD_W-1:0];
        end else begin
            result = req.origin;
        end
    end

endmodule

### rtl/core/pmt_checker.sv
module pmt_checker #(
    parameter int MAX_POINTS = pmt_pkg::MAX_POINTS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pmt_pkg::M_TDATA_W-1:0]       m_tdata
);

    logic [7:0] out_sel;
    logic [7:0] out_count;

    assign out_sel   = m_tdata[8:1];
    assign out_count = m_tdata[16:9];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_POINTS > 255) || (out_count <= 8'(MAX_POINTS)))
        else $error("marker count beyond table size");

    a_sel_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_count != 8'd0 |->
            (MAX_POINTS > 127) || (!out_sel[7] && out_sel < out_count))
        else $error("selection outside stored markers");

endmodule

bind point_marker_table pmt_checker #(.MAX_POINTS(MAX_POINTS)) u_pmt_checker (.*);
